// ----- sv/gcd_pkg.sv -----
// Shared constants and helper functions for the great-circle distance block.
// Used by gcd_cordic, gcd_isqrt and great_circle_distance_top; no dependencies.
`default_nettype none

package gcd_pkg;

  localparam int unsigned CORDIC_W = 34;
  localparam int unsigned Z_OUT_W = 31;
  localparam int unsigned ROOT_W = 31;
  localparam int unsigned H_W = 61;
  localparam int unsigned ACC_W = 62;
  localparam int unsigned SQRT_STAGES = 31;
  localparam int unsigned LANES = 4;

  localparam logic signed [26:0] FULL_TURN = 27'sd23592960;
  localparam logic signed [26:0] TWO_TURNS = 27'sd47185920;
  localparam logic [29:0] RECIP45 = 30'd763549742;
  localparam logic [5:0] DIV45 = 6'd45;
  localparam logic [18:0] HALF_STEP = 19'd22;
  localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [H_W-1:0] Q60_ONE = 61'h1000_0000_0000_0000;
  localparam logic [Z_OUT_W-1:0] QUARTER_TURN = 31'h4000_0000;
  localparam logic [15:0] RADIUS_RESET = 16'd6371;

  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0: v = 30'd536870912;
      5'd1: v = 30'd316933406;
      5'd2: v = 30'd167458907;
      5'd3: v = 30'd85004756;
      5'd4: v = 30'd42667331;
      5'd5: v = 30'd21354465;
      5'd6: v = 30'd10679838;
      5'd7: v = 30'd5340245;
      5'd8: v = 30'd2670163;
      5'd9: v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // reduce a coordinate difference to [0, one turn)
  function automatic logic [24:0] wrap_turn(input logic signed [26:0] d);
    logic signed [26:0] w;
    if (d < 0) begin
      if (d < -FULL_TURN) begin
        w = d + TWO_TURNS;
      end else begin
        w = d + FULL_TURN;
      end
    end else if (d >= FULL_TURN) begin
      w = d - FULL_TURN;
    end else begin
      w = d;
    end
    return w[24:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/gcd_cordic.sv -----
// Pipelined CORDIC, one iteration per register stage, rotation or vectoring.
// Depends on gcd_pkg for widths and the arctangent table.
`default_nettype none

module gcd_cordic #(
  parameter int unsigned STAGES = 20,
  parameter bit VECTORING = 1'b0
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 en_i,
  input  wire logic signed [gcd_pkg::CORDIC_W-1:0]  x_i,
  input  wire logic signed [gcd_pkg::CORDIC_W-1:0]  y_i,
  input  wire logic signed [gcd_pkg::CORDIC_W-1:0]  z_i,
  input  wire logic                                 neg_i,
  output logic signed [gcd_pkg::CORDIC_W-1:0]       x_o,
  output logic signed [gcd_pkg::CORDIC_W-1:0]       y_o,
  output logic [gcd_pkg::Z_OUT_W-1:0]               z_o
);

  localparam int unsigned W = gcd_pkg::CORDIC_W;

  logic signed [W-1:0] xs [STAGES+1];
  logic signed [W-1:0] ys [STAGES+1];
  logic signed [W-1:0] zs [STAGES+1];
  logic                ns [STAGES+1];

  assign xs[0] = x_i;
  assign ys[0] = y_i;
  assign zs[0] = z_i;
  assign ns[0] = neg_i;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [W-1:0] ATAN_I = W'(gcd_pkg::atan_turn(5'(i)));
    logic signed [W-1:0] x_q, y_q, z_q;
    logic                n_q;
    logic                rot_pos;

    assign rot_pos = VECTORING ? ys[i][W-1] : !zs[i][W-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rot_pos) begin
          x_q <= xs[i] - (ys[i] >>> i);
          y_q <= ys[i] + (xs[i] >>> i);
          z_q <= zs[i] - ATAN_I;
        end else begin
          x_q <= xs[i] + (ys[i] >>> i);
          y_q <= ys[i] - (xs[i] >>> i);
          z_q <= zs[i] + ATAN_I;
        end
        n_q <= ns[i];
      end
    end

    assign xs[i+1] = x_q;
    assign ys[i+1] = y_q;
    assign zs[i+1] = z_q;
    assign ns[i+1] = n_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o <= ns[STAGES] ? -xs[STAGES] : xs[STAGES];
      y_o <= ns[STAGES] ? -ys[STAGES] : ys[STAGES];
      if (zs[STAGES][W-1]) begin
        z_o <= '0;
      end else if (zs[STAGES] > W'(gcd_pkg::QUARTER_TURN)) begin
        z_o <= gcd_pkg::QUARTER_TURN;
      end else begin
        z_o <= zs[STAGES][gcd_pkg::Z_OUT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/gcd_isqrt.sv -----
// Pipelined floor square root, one result bit per register stage.
// Depends on gcd_pkg for widths and stage count.
`default_nettype none

module gcd_isqrt (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [gcd_pkg::H_W-1:0]       val_i,
  output logic [gcd_pkg::ROOT_W-1:0]         root_o
);

  localparam int unsigned N = gcd_pkg::SQRT_STAGES;
  localparam int unsigned AW = gcd_pkg::ACC_W;

  logic [AW-1:0] rem_s [N+1];
  logic [AW-1:0] res_s [N+1];

  assign rem_s[0] = AW'(val_i);
  assign res_s[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [AW-1:0] BIT_K = AW'(1) << (2 * (N - 1 - k));
    logic [AW-1:0] cand;
    logic [AW-1:0] rem_q, res_q;

    assign cand = res_s[k] + BIT_K;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_s[k] >= cand) begin
          rem_q <= rem_s[k] - cand;
          res_q <= (res_s[k] >> 1) + BIT_K;
        end else begin
          rem_q <= rem_s[k];
          res_q <= res_s[k] >> 1;
        end
      end
    end

    assign rem_s[k+1] = rem_q;
    assign res_s[k+1] = res_q;
  end

  assign root_o = res_s[N][gcd_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

// ----- sv/great_circle_distance_top.sv -----
// Haversine great-circle distance pipeline: angle conversion, sin/cos CORDICs,
// haversine sum, square roots, vectoring CORDIC and radius scaling.
// Depends on gcd_pkg, gcd_cordic and gcd_isqrt.
//
// Usage:
//   Request channel in_valid_i/in_ready_o carries two points (lat/lon in
//   degrees * 65536). Result channel out_valid_o/out_ready_i carries the
//   distance in 1/16 km. Config channel cfg_valid_i/cfg_ready_o writes the
//   sphere radius in km (reset 6371); write it only while the block is idle.
//   Throughput: one request per cycle while in_ready_o is high. Most of the
//   pipeline depth comes from the two CORDIC pipelines and the 31-stage
//   square root.
//   Reset clears all valid bits and loads the default radius.
//   When the receiver stalls, one result waits in the output register and
//   the next lands in a skid register; only then does in_ready_o drop and
//   the whole pipeline hold.
`default_nettype none

module great_circle_distance_top #(
  parameter int unsigned CORDIC_STAGES = 20
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [23:0] start_lat_i,
  input  wire logic signed [24:0] start_lon_i,
  input  wire logic signed [23:0] dest_lat_i,
  input  wire logic signed [24:0] dest_lon_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [24:0]             distance_o
);

  localparam int unsigned W = gcd_pkg::CORDIC_W;
  localparam int unsigned NL = gcd_pkg::LANES;
  localparam int unsigned PIPE_DEPTH = 2 * CORDIC_STAGES + 46;
  localparam logic [NL-1:0] FULL_LANE = 4'b0011;

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld_q;
  logic [15:0]           rad_q;
  logic                  out_v_q, skid_v_q;
  logic [24:0]           out_q, skid_q;

  assign en = !skid_v_q;
  assign in_ready_o = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q <= gcd_pkg::RADIUS_RESET;
    end else if (cfg_valid_i) begin
      rad_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  logic signed [26:0] lane_d [NL];
  logic signed [W-1:0] rot_x [NL];
  logic signed [W-1:0] rot_y [NL];

  always_comb begin
    lane_d[0] = 27'(start_lat_i);
    lane_d[1] = 27'(dest_lat_i);
    lane_d[2] = 27'(dest_lat_i) - 27'(start_lat_i);
    lane_d[3] = 27'(dest_lon_i) - 27'(start_lon_i);
  end

  for (genvar l = 0; l < NL; l++) begin : g_lane
    logic [24:0]         m1_q, m2_q;
    logic [54:0]         p2_q;
    logic [19:0]         q3_q, q4_q;
    logic [18:0]         n3_q;
    logic [48:0]         p4_q;
    logic signed [W-1:0] z5_q;
    logic                neg5_q;
    logic [19:0]         q3;
    logic [24:0]         rem_full;
    logic [5:0]          r3;
    logic [13:0]         t5;
    logic [31:0]         ang;
    logic                flip;

    assign q3 = p2_q[54:35];
    assign rem_full = m2_q - 25'(q3) * 25'(gcd_pkg::DIV45);
    assign r3 = rem_full[5:0];
    assign t5 = p4_q[48:35];
    assign ang = FULL_LANE[l] ? 32'({q4_q, 13'd0} + 33'(t5))
                              : 32'({q4_q, 12'd0}) + 32'(t5);
    assign flip = ang[31] ^ ang[30];

    always_ff @(posedge clk_i) begin
      if (en) begin
        m1_q <= gcd_pkg::wrap_turn(lane_d[l]);
        p2_q <= 55'(m1_q) * 55'(gcd_pkg::RECIP45);
        m2_q <= m1_q;
        q3_q <= q3;
        n3_q <= FULL_LANE[l] ? ({r3, 13'd0} + gcd_pkg::HALF_STEP)
                             : (19'({r3, 12'd0}) + gcd_pkg::HALF_STEP);
        p4_q <= 49'(n3_q) * 49'(gcd_pkg::RECIP45);
        q4_q <= q3_q;
        z5_q <= W'($signed({ang[31] ^ flip, ang[30:0]}));
        neg5_q <= flip;
      end
    end

    gcd_cordic #(
      .STAGES    (CORDIC_STAGES),
      .VECTORING (1'b0)
    ) u_rot (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (gcd_pkg::GAIN_Q30),
      .y_i   ('0),
      .z_i   (z5_q),
      .neg_i (neg5_q),
      .x_o   (rot_x[l]),
      .y_o   (rot_y[l]),
      .z_o   ()
    );
  end

  logic signed [63:0]     c12_q, asq_a_q, bsq_q;
  logic signed [63:0]     asq_b_q, asq_c_q;
  logic signed [31:0]     cc_q;
  logic [31:0]            b2_q;
  logic signed [64:0]     pr_q;
  logic [gcd_pkg::H_W-1:0] h_q, hs_q, hc_q;
  logic signed [65:0]     hsum;
  logic signed [63:0]     cc_full, b2_full;

  assign cc_full = (c12_q + 64'sd536870912) >>> 30;
  assign b2_full = (bsq_q + 64'sd536870912) >>> 30;
  assign hsum = 66'(asq_c_q) + 66'(pr_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      c12_q <= $signed(rot_x[0][31:0]) * $signed(rot_x[1][31:0]);
      asq_a_q <= $signed(rot_y[2][31:0]) * $signed(rot_y[2][31:0]);
      bsq_q <= $signed(rot_y[3][31:0]) * $signed(rot_y[3][31:0]);
      cc_q <= cc_full[31:0];
      b2_q <= b2_full[31:0];
      asq_b_q <= asq_a_q;
      pr_q <= 65'(cc_q) * $signed({1'b0, b2_q});
      asq_c_q <= asq_b_q;
      if (hsum < 0) begin
        h_q <= '0;
      end else if (hsum > 66'(gcd_pkg::Q60_ONE)) begin
        h_q <= gcd_pkg::Q60_ONE;
      end else begin
        h_q <= hsum[gcd_pkg::H_W-1:0];
      end
      hs_q <= h_q;
      hc_q <= gcd_pkg::Q60_ONE - h_q;
    end
  end

  logic [gcd_pkg::ROOT_W-1:0] root_s, root_c;

  gcd_isqrt u_sqrt_h (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  (hs_q),
    .root_o (root_s)
  );

  gcd_isqrt u_sqrt_hc (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  (hc_q),
    .root_o (root_c)
  );

  logic [gcd_pkg::Z_OUT_W-1:0] zc;

  gcd_cordic #(
    .STAGES    (CORDIC_STAGES),
    .VECTORING (1'b1)
  ) u_vec (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   ($signed(W'(root_c))),
    .y_i   ($signed(W'(root_s))),
    .z_i   ('0),
    .neg_i (1'b0),
    .x_o   (),
    .y_o   (),
    .z_o   (zc)
  );

  logic [62:0] wp_q;
  logic [54:0] dk_q;
  logic [24:0] dist_q;
  logic [55:0] dround;

  assign dround = 56'(dk_q) + 56'h8000_0000;

  always_ff @(posedge clk_i) begin
    if (en) begin
      wp_q <= 63'(zc) * 63'(gcd_pkg::PI_Q30);
      dk_q <= 55'(wp_q[62:24]) * 55'(rad_q);
      dist_q <= 25'(dround[55:32]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_v_q <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= vld_q[PIPE_DEPTH-1];
      end
    end else if (vld_q[PIPE_DEPTH-1] && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      out_q <= skid_v_q ? skid_q : dist_q;
    end else if (en) begin
      skid_q <= dist_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign distance_o = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register holds a result while output register is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_ready_i && vld_q[PIPE_DEPTH-1]))
    else $error("skid register filled without a stalled result");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> rad_q == $past(cfg_data_i))
    else $error("radius register missed a write");

endmodule

`default_nettype wire
